>>> rtl/core/palette_sprite_line_compositor_unit_assert.svh
// Assertion macros for the scanline compositor.
`ifndef PALETTE_SPRITE_LINE_COMPOSITOR_UNIT_ASSERT_SVH
`define PALETTE_SPRITE_LINE_COMPOSITOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("compositor check failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define PSLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("compositor check failed (next cycle)");

`endif

>>> rtl/core/pslc_pkg.sv
`timescale 1ns / 1ps

package pslc_pkg;

    localparam int LINE_PIXELS_DEF = 256;
    localparam int LANES           = 4;
    localparam int PAL_DEPTH       = 16;
    localparam int IDX_W           = 4;
    localparam int COLOR_W         = 16;
    localparam int X_W             = 8;
    localparam int BYTE_W          = 8;

    typedef enum logic [1:0] {
        OP_FILL    = 2'd0,
        OP_PALETTE = 2'd1,
        OP_DRAW    = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    localparam logic [IDX_W-1:0] MASK_FOUR_BIT = 4'hF;
    localparam logic [IDX_W-1:0] MASK_TWO_BIT  = 4'h3;

    typedef logic [2:0] shift_t;
    localparam shift_t SHIFT_TWO_BIT  [LANES] = '{3'd6, 3'd4, 3'd2, 3'd0};
    localparam shift_t SHIFT_FOUR_BIT [2]     = '{3'd4, 3'd0};

    // Palette index carried by one lane of a packed byte, most significant first.
    function automatic logic [IDX_W-1:0] lane_index(
        input logic [BYTE_W-1:0] bits,
        input logic              wide,
        input logic [1:0]        lane
    );
        logic [BYTE_W-1:0] shifted;
        if (wide) begin
            shifted = bits >> SHIFT_FOUR_BIT[lane[0]];
            return shifted[IDX_W-1:0] & MASK_FOUR_BIT;
        end
        shifted = bits >> SHIFT_TWO_BIT[lane];
        return shifted[IDX_W-1:0] & MASK_TWO_BIT;
    endfunction

endpackage

>>> rtl/core/palette_sprite_line_compositor_unit.sv
`timescale 1ns / 1ps

// Channel    | Handshake       | Ports
// -----------+-----------------+------------------------------------------------
// command in | start & !busy   | op, pixel_x, color_value, palette_slot,
//            |                 | packed_indices, depth_mode, transparent_index
// result out | done strobe     | pixel_color
//
// One command word is taken every clock; busy never rises and the receiver cannot stall.
// The accept edge writes the palette and looks up the lane colors; the next edge
// writes the pixel banks and registers a read's word onto the ports, together
// with the done strobe.
// Reset and each fill clear all per-pixel valid bits and set the fill color
// (zero at reset); a pixel whose valid bit is clear reads as that color.

module palette_sprite_line_compositor_unit
    import pslc_pkg::*;
#(
    parameter int LINE_PIXELS = LINE_PIXELS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [X_W-1:0]     pixel_x,
    input  logic [COLOR_W-1:0] color_value,
    input  logic [IDX_W-1:0]   palette_slot,
    input  logic [BYTE_W-1:0]  packed_indices,
    input  logic               depth_mode,
    input  logic [IDX_W-1:0]   transparent_index,
    output logic               done,
    output logic [COLOR_W-1:0] pixel_color
);

    `include "palette_sprite_line_compositor_unit_assert.svh"

    // Pixels are spread over four banks by x mod 4, so a packed byte
    // touches each bank at most once.
    localparam int BANK_DEPTH = (LINE_PIXELS + LANES - 1) / LANES;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int VW         = $clog2(LINE_PIXELS);
    localparam int PW         = X_W + 1;

    logic accept;
    op_t  in_op;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign in_op  = op_t'(op);

    // ---------------- stage 1: palette write and lane lookup ----------------
    logic [COLOR_W-1:0] pal_mem [LANES][PAL_DEPTH];
    logic [COLOR_W-1:0] pal_rd_reg [LANES];
    logic [IDX_W-1:0]   lane_idx [LANES];
    logic [LANES-1:0]   skip_next;

    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic [X_W-1:0]     s1_x_reg;
    logic [COLOR_W-1:0] s1_color_reg;
    logic               s1_wide_reg;
    logic [LANES-1:0]   s1_skip_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_idx[l]  = lane_index(packed_indices, depth_mode, 2'(l));
            skip_next[l] = (lane_idx[l] == transparent_index);
        end
    end

    // Four palette copies, one read port each; a palette write hits all of them.
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (accept && in_op == OP_PALETTE)
            begin
                pal_mem[l][palette_slot] <= color_value;
            end
            pal_rd_reg[l] <= pal_mem[l][lane_idx[l]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= in_op;
            s1_x_reg     <= pixel_x;
            s1_color_reg <= color_value;
            s1_wide_reg  <= depth_mode;
            s1_skip_reg  <= skip_next;
        end
    end

    // ---------------- stage 2: bank writes, fill, pixel read ----------------
    logic [COLOR_W-1:0]     bank_mem [LANES][BANK_DEPTH];
    logic [COLOR_W-1:0]     bank_rd_reg [LANES];
    logic [LANES-1:0]       bank_we;
    logic [AW-1:0]          bank_addr [LANES];
    logic [COLOR_W-1:0]     bank_wd [LANES];
    logic [PW-1:0]          bank_pos [LANES];
    logic [AW-1:0]          rd_addr;

    logic [LINE_PIXELS-1:0] valid_reg;
    logic [LINE_PIXELS-1:0] valid_next;
    logic [COLOR_W-1:0]     fill_color_reg;
    logic [COLOR_W-1:0]     fill_color_next;

    logic                   rd_valid_reg;
    logic [1:0]             rd_bank_reg;
    logic                   rd_hit_reg;
    logic                   rd_hit_next;
    logic [COLOR_W-1:0]     rd_fill_reg;
    logic [COLOR_W-1:0]     rd_fill_next;
    logic                   rd_in_range;
    logic                   s1_draw;
    logic                   s1_fill;
    logic                   s1_read;

    assign s1_draw     = s1_valid_reg && s1_op_reg == OP_DRAW;
    assign s1_fill     = s1_valid_reg && s1_op_reg == OP_FILL;
    assign s1_read     = s1_valid_reg && s1_op_reg == OP_READ;
    assign rd_addr     = AW'(s1_x_reg[X_W-1:2]);
    assign rd_in_range = (32'(s1_x_reg) < LINE_PIXELS);

    // Route each lane to the bank that owns its pixel.
    always_comb
    begin
        logic [1:0] lane;
        for (int b = 0; b < LANES; b++)
        begin
            lane         = 2'(2'(b) - s1_x_reg[1:0]);
            bank_pos[b]  = PW'(s1_x_reg) + PW'(lane);
            bank_addr[b] = AW'(bank_pos[b][PW-1:2]);
            bank_wd[b]   = pal_rd_reg[lane];
            bank_we[b]   = s1_draw
                           && (!s1_wide_reg || lane[1] == 1'b0)
                           && !s1_skip_reg[lane]
                           && (32'(bank_pos[b]) < LINE_PIXELS);
        end
    end

    // Fill wipes every valid bit; drawn pixels become valid.
    always_comb
    begin
        valid_next      = valid_reg;
        fill_color_next = fill_color_reg;
        if (s1_fill)
        begin
            valid_next      = '0;
            fill_color_next = s1_color_reg;
        end
        else
        begin
            for (int b = 0; b < LANES; b++)
            begin
                if (bank_we[b])
                begin
                    valid_next[VW'(bank_pos[b])] = 1'b1;
                end
            end
        end
    end

    // Snapshot what a read needs: a hit selects bank data, otherwise the
    // fill color, and zero past the line end.
    always_comb
    begin
        rd_hit_next  = 1'b0;
        rd_fill_next = '0;
        if (rd_in_range)
        begin
            rd_hit_next  = valid_reg[VW'(s1_x_reg)];
            rd_fill_next = fill_color_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < LANES; b++)
        begin
            if (bank_we[b])
            begin
                bank_mem[b][bank_addr[b]] <= bank_wd[b];
            end
            bank_rd_reg[b] <= bank_mem[b][rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_read)
        begin
            rd_bank_reg <= s1_x_reg[1:0];
            rd_hit_reg  <= rd_hit_next;
            rd_fill_reg <= rd_fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            rd_valid_reg   <= 1'b0;
            valid_reg      <= '0;
            fill_color_reg <= '0;
        end
        else
        begin
            s1_valid_reg   <= accept;
            rd_valid_reg   <= s1_read;
            valid_reg      <= valid_next;
            fill_color_reg <= fill_color_next;
        end
    end

    assign done        = rd_valid_reg;
    assign pixel_color = rd_hit_reg ? bank_rd_reg[rd_bank_reg] : rd_fill_reg;

    // ---------------- checks ----------------
    `PSLC_ASSERT_NEXT(a_accept_enters, clk, rst_n, accept, s1_valid_reg)
    `PSLC_ASSERT_NEXT(a_read_gives_word, clk, rst_n, s1_read, done)
    `PSLC_ASSERT_NEXT(a_no_spurious_word, clk, rst_n, !s1_read, !done)
    `PSLC_ASSERT_NEXT(a_fill_clears, clk, rst_n, s1_fill, valid_reg == '0)

endmodule

>>> verif/palette_sprite_line_compositor_unit_tb.sv
`timescale 1ns / 1ps

// Scanline compositor testbench.
//
// A shadow copy of the line buffer and the palette follows every command word
// accepted by the block. Each read pushes the color it must return onto a
// queue. The result monitor pops the oldest entry on every done strobe and
// compares it with pixel_color. The stimulus runs in order: a directed block
// of named tests, then three random phases with different sender idle rates.

module palette_sprite_line_compositor_unit_tb;

    import pslc_pkg::*;

    localparam int LINE_PIXELS = LINE_PIXELS_DEF;
    localparam int CLK_HALF    = 5;
    // A read's word comes out through the stage 1 and stage 2 registers. Wait TAIL_CYCLES more after the queue drains.
    localparam int TAIL_CYCLES = 4;
    localparam int DRAIN_LIMIT = 200;
    localparam int MAX_REPORTS = 20;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         op;
    logic [X_W-1:0]     pixel_x;
    logic [COLOR_W-1:0] color_value;
    logic [IDX_W-1:0]   palette_slot;
    logic [BYTE_W-1:0]  packed_indices;
    logic               depth_mode;
    logic [IDX_W-1:0]   transparent_index;
    logic               done;
    logic [COLOR_W-1:0] pixel_color;

    // Shadow state of the block, updated once per accepted word.
    logic [COLOR_W-1:0] shadow_line    [LINE_PIXELS];
    logic [COLOR_W-1:0] shadow_palette [PAL_DEPTH];
    // Colors that pending reads must return, oldest first.
    logic [COLOR_W-1:0] expected_colors [$];
    int                 fail_count;
    // Last draw position, so that reads can land on freshly drawn pixels.
    logic [X_W-1:0]     last_draw_x;

    palette_sprite_line_compositor_unit u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .op                (op),
        .pixel_x           (pixel_x),
        .color_value       (color_value),
        .palette_slot      (palette_slot),
        .packed_indices    (packed_indices),
        .depth_mode        (depth_mode),
        .transparent_index (transparent_index),
        .done              (done),
        .pixel_color       (pixel_color)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Stop a hung run. The slowest correct run ends far sooner than this.
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Apply one accepted command word to the shadow line and palette.
    // For a read, queue the color that the block must return.
    task automatic composite_word(
        input logic [1:0]         w_op,
        input logic [X_W-1:0]     w_x,
        input logic [COLOR_W-1:0] w_color,
        input logic [IDX_W-1:0]   w_slot,
        input logic [BYTE_W-1:0]  w_bits,
        input logic               w_depth,
        input logic [IDX_W-1:0]   w_transp
    );
        int               pos;
        int               lanes;
        logic [IDX_W-1:0] idx;
        logic [BYTE_W-1:0] shifted;
        unique case (op_t'(w_op))
            OP_FILL:
            begin
                for (int i = 0; i < LINE_PIXELS; i++)
                    shadow_line[i] = w_color;
            end
            OP_PALETTE:
            begin
                shadow_palette[w_slot] = w_color;
            end
            OP_DRAW:
            begin
                lanes = w_depth ? 2 : LANES;
                for (int lane = 0; lane < lanes; lane++)
                begin
                    // Take indices from the most significant end first.
                    if (w_depth)
                    begin
                        shifted = w_bits >> (4 - 4 * lane);
                        idx = shifted[IDX_W-1:0] & MASK_FOUR_BIT;
                    end
                    else
                    begin
                        shifted = w_bits >> (6 - 2 * lane);
                        idx = shifted[IDX_W-1:0] & MASK_TWO_BIT;
                    end
                    pos = int'(w_x) + lane;
                    // Skip the transparent index; drop pixels past the line end.
                    if (idx != w_transp && pos < LINE_PIXELS)
                        shadow_line[X_W'(pos)] = shadow_palette[idx];
                end
            end
            OP_READ:
            begin
                if (int'(w_x) < LINE_PIXELS)
                    expected_colors.push_back(shadow_line[w_x]);
                else
                    expected_colors.push_back('0);
            end
        endcase
    endtask

    // Result monitor and predictor share one process. This fixes the order of
    // queue operations within an edge: check the strobe first, then record the
    // word accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_colors.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result with no read pending, expected none actual %h",
                                 $time, pixel_color);
                end
                else
                begin
                    if (pixel_color !== expected_colors[0])
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: pixel_color mismatch, expected %h actual %h",
                                     $time, expected_colors[0], pixel_color);
                    end
                    void'(expected_colors.pop_front());
                end
            end
            if (start && !busy)
                composite_word(op, pixel_x, color_value, palette_slot,
                               packed_indices, depth_mode, transparent_index);
        end
    end

    // Present one word and hold it until the block takes it. Leave start high:
    // the caller either sends the next word or idles.
    task automatic send_word(
        input op_t                w_op,
        input logic [X_W-1:0]     w_x,
        input logic [COLOR_W-1:0] w_color,
        input logic [IDX_W-1:0]   w_slot,
        input logic [BYTE_W-1:0]  w_bits,
        input logic               w_depth,
        input logic [IDX_W-1:0]   w_transp
    );
        start             <= 1'b1;
        op                <= w_op;
        pixel_x           <= w_x;
        color_value       <= w_color;
        palette_slot      <= w_slot;
        packed_indices    <= w_bits;
        depth_mode        <= w_depth;
        transparent_index <= w_transp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (w_op == OP_DRAW)
            last_draw_x = w_x;
    endtask

    // Idle the sender for a random number of cycles, at idle_pct percent per cycle.
    task automatic idle_gap(input int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    // Hold off the sender until every pending read has returned.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (expected_colors.size() != 0)
            @(posedge clk);
    endtask

    task automatic read_pixel(input logic [X_W-1:0] x);
        send_word(OP_READ, x, 16'($urandom), 4'($urandom), 8'($urandom),
                  1'($urandom), 4'($urandom));
    endtask

    // After reset the line must read as zero; check the first and the last pixel.
    task automatic test_reset_state();
        read_pixel(8'd0);
        read_pixel(8'd255);
    endtask

    // Load every palette entry before any draw can use it. Include both color
    // extremes, and random colors for the entries between them.
    task automatic test_palette_load();
        for (int s = 0; s < PAL_DEPTH; s++)
        begin
            if (s == 0)
                send_word(OP_PALETTE, 8'($urandom), 16'h0000, 4'(s), 8'($urandom),
                          1'($urandom), 4'($urandom));
            else if (s == PAL_DEPTH - 1)
                send_word(OP_PALETTE, 8'($urandom), 16'hFFFF, 4'(s), 8'($urandom),
                          1'($urandom), 4'($urandom));
            else
                send_word(OP_PALETTE, 8'($urandom), 16'($urandom), 4'(s),
                          8'($urandom), 1'($urandom), 4'($urandom));
        end
    endtask

    task automatic test_fill();
        send_word(OP_FILL, 8'd0, 16'hFFFF, 4'd0, 8'd0, 1'b0, 4'd0);
        read_pixel(8'd128);
    endtask

    // Draw four 2-bit indices from pixel 0; index 0 is transparent.
    task automatic test_draw_two_bit();
        send_word(OP_DRAW, 8'd0, 16'd0, 4'd0, 8'b00_01_10_11, 1'b0, 4'd0);
        read_pixel(8'd0);
        read_pixel(8'd3);
    endtask

    // Draw two 4-bit indices at the line end. The second pixel falls past it.
    task automatic test_draw_four_bit_past_end();
        send_word(OP_DRAW, 8'd255, 16'hFFFF, 4'hF, 8'hE7, 1'b1, 4'h0);
        read_pixel(8'd255);
    endtask

    // A transparent index above three never matches a 2-bit index, so every lane
    // within the line is written. Start at 254 so that two lanes fall past the line end.
    task automatic test_transparent_high();
        send_word(OP_DRAW, 8'd254, 16'h0000, 4'h0, 8'h00, 1'b0, 4'hF);
        read_pixel(8'd254);
        read_pixel(8'd255);
        send_word(OP_FILL, 8'hFF, 16'h0000, 4'hF, 8'hFF, 1'b1, 4'hF);
        read_pixel(8'd255);
    endtask

    // Random words, weighted toward draws and the reads that check them.
    // Keep fills rare so that the drawn content builds up.
    task automatic test_random(input int count, input int idle_pct);
        int               pick;
        logic [X_W-1:0]   x;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                send_word(OP_FILL, 8'($urandom), 16'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom), 4'($urandom));
            end
            else if (pick < 14)
            begin
                send_word(OP_PALETTE, 8'($urandom), 16'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom), 4'($urandom));
            end
            else if (pick < 60)
            begin
                // Aim one draw in eight at the line end.
                if ($urandom_range(7) == 0)
                    x = 8'($urandom_range(LINE_PIXELS - 1, LINE_PIXELS - 8));
                else
                    x = 8'($urandom);
                send_word(OP_DRAW, x, 16'($urandom), 4'($urandom), 8'($urandom),
                          1'($urandom), 4'($urandom));
            end
            else
            begin
                // Aim most reads at the pixels that the last draw covered.
                if ($urandom_range(2) != 0)
                    x = last_draw_x + 8'($urandom_range(3));
                else
                    x = 8'($urandom);
                read_pixel(x);
            end
            idle_gap(idle_pct);
        end
    endtask

    initial
    begin
        int waited;
        fail_count        = 0;
        last_draw_x       = '0;
        for (int i = 0; i < LINE_PIXELS; i++)
            shadow_line[i] = '0;
        for (int i = 0; i < PAL_DEPTH; i++)
            shadow_palette[i] = '0;
        rst_n             = 1'b0;
        start             <= 1'b0;
        op                <= OP_FILL;
        pixel_x           <= '0;
        color_value       <= '0;
        palette_slot      <= '0;
        packed_indices    <= '0;
        depth_mode        <= 1'b0;
        transparent_index <= '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_palette_load();
        test_fill();
        test_draw_two_bit();
        test_draw_four_bit_past_end();
        test_transparent_high();
        drain_results();

        test_random(600, 30);
        drain_results();
        test_random(600, 84);
        drain_results();
        test_random(550, 0);
        start <= 1'b0;

        // Wait for the last reads, bounded, then let the pipeline settle.
        waited = 0;
        while (expected_colors.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (expected_colors.size() != 0)
        begin
            fail_count++;
            $display("%0t: reads left unanswered, expected %0d results actual 0",
                     $time, expected_colors.size());
        end
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
